// ===== rtl/romaji_kana_composer_macros.svh =====
// ----------------------------------------------------------------------------
// Romaji kana composer assertion macros
// Shared assertion wrappers; they reduce to nothing when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ROMAJI_KANA_COMPOSER_MACROS_SVH
`define ROMAJI_KANA_COMPOSER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RKC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("romaji_kana_composer: check failed");
`define RKC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("romaji_kana_composer: check failed");
`else
`define RKC_ASSERT_SAME(lbl, ante, cons)
`define RKC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/rkc_pkg.sv =====
// ----------------------------------------------------------------------------
// Romaji kana composer package
// Codes, the lookup result type and the romaji table as decoder functions.
// ----------------------------------------------------------------------------
package rkc_pkg;

	localparam int MAX_PENDING = 4;
	localparam int CODE_W = 21;

	localparam logic [1:0] REQ_KEY    = 2'd0;
	localparam logic [1:0] REQ_FLUSH  = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	localparam logic [1:0] KIND_CHAR    = 2'd0;
	localparam logic [1:0] KIND_RETRACT = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;

	localparam logic [CODE_W-1:0] SMALL_TSU  = 21'h03063;
	localparam logic [CODE_W-1:0] SYLL_N     = 21'h03093;
	localparam logic [CODE_W-1:0] CH_COMMA   = 21'h0002C;
	localparam logic [CODE_W-1:0] CH_PERIOD  = 21'h0002E;
	localparam logic [CODE_W-1:0] CH_LOWER_N = 21'h0006E;
	localparam logic [CODE_W-1:0] CH_LOWER_T = 21'h00074;
	localparam logic [CODE_W-1:0] CH_LOWER_C = 21'h00063;

	typedef struct packed {
		logic              match;
		logic              ext;
		logic [CODE_W-1:0] v0;
		logic [15:0]       v1;
	} lookup_t;

	function automatic logic is_doubling(input logic [CODE_W-1:0] c);
		logic res;
		res = (c >= 21'h61) && (c <= 21'h7A) && (c != 21'h61) && (c != 21'h65) &&
			(c != 21'h69) && (c != 21'h6F) && (c != 21'h75) && (c != 21'h6E);
		return res;
	endfunction

	// Keys are packed right-justified, the first character in the highest used byte.
	function automatic logic kana_prefix(input logic [31:0] key);
		logic res;
		res = 1'b0;
		unique case (key)
			"b", "c", "d", "f", "g", "h", "j", "k", "l", "m", "n", "p", "q", "r", "s",
			"t", "v", "w", "x", "y", "z",
			"ky", "gy", "sh", "sy", "jy", "zy", "ch", "ty", "ts", "th", "tw", "dy",
			"dh", "dw", "ny", "hy", "fy", "by", "py", "my", "ry", "wh", "lt", "xt",
			"ly", "xy", "lw", "xw", "xk",
			"lts": res = 1'b1;
			default: res = 1'b0;
		endcase
		return res;
	endfunction

	// Upper half is the first code, lower half the second; zero means no key.
	function automatic logic [31:0] kana_value(input logic [31:0] key);
		logic [31:0] v;
		v = 32'h0;
		unique case (key)
			"a": v = 32'h30420000; "i": v = 32'h30440000; "u": v = 32'h30460000;
			"e": v = 32'h30480000; "o": v = 32'h304A0000;
			"ka": v = 32'h304B0000; "ki": v = 32'h304D0000; "ku": v = 32'h304F0000;
			"ke": v = 32'h30510000; "ko": v = 32'h30530000;
			"kya": v = 32'h304D3083; "kyi": v = 32'h304D3043; "kyu": v = 32'h304D3085;
			"kye": v = 32'h304D3047; "kyo": v = 32'h304D3087;
			"ga": v = 32'h304C0000; "gi": v = 32'h304E0000; "gu": v = 32'h30500000;
			"ge": v = 32'h30520000; "go": v = 32'h30540000;
			"gya": v = 32'h304E3083; "gyu": v = 32'h304E3085; "gyo": v = 32'h304E3087;
			"sa": v = 32'h30550000; "si": v = 32'h30570000; "su": v = 32'h30590000;
			"se": v = 32'h305B0000; "so": v = 32'h305D0000;
			"sha": v = 32'h30573083; "shu": v = 32'h30573085; "sho": v = 32'h30573087;
			"shi": v = 32'h30570000; "she": v = 32'h30573047;
			"sya": v = 32'h30573083; "syi": v = 32'h30573043; "syu": v = 32'h30573085;
			"sye": v = 32'h30573047; "syo": v = 32'h30573087;
			"za": v = 32'h30560000; "zi": v = 32'h30580000; "zu": v = 32'h305A0000;
			"ze": v = 32'h305C0000; "zo": v = 32'h305E0000;
			"ja": v = 32'h30583083; "ju": v = 32'h30583085; "jo": v = 32'h30583087;
			"ji": v = 32'h30580000; "je": v = 32'h30583047;
			"jya": v = 32'h30583083; "jyu": v = 32'h30583085; "jyo": v = 32'h30583087;
			"zya": v = 32'h30583083; "zyi": v = 32'h30583043; "zyu": v = 32'h30583085;
			"zye": v = 32'h30583047; "zyo": v = 32'h30583087;
			"ta": v = 32'h305F0000; "ti": v = 32'h30610000; "tu": v = 32'h30640000;
			"te": v = 32'h30660000; "to": v = 32'h30680000;
			"cha": v = 32'h30613083; "chu": v = 32'h30613085; "cho": v = 32'h30613087;
			"chi": v = 32'h30610000; "che": v = 32'h30613047;
			"tya": v = 32'h30613083; "tyi": v = 32'h30613043; "tyu": v = 32'h30613085;
			"tye": v = 32'h30613047; "tyo": v = 32'h30613087;
			"tsu": v = 32'h30640000;
			"tsa": v = 32'h30643041; "tsi": v = 32'h30643043; "tse": v = 32'h30643047;
			"tso": v = 32'h30643049;
			"tha": v = 32'h30663083; "thi": v = 32'h30663043; "thu": v = 32'h30663085;
			"the": v = 32'h30663047; "tho": v = 32'h30663087;
			"twu": v = 32'h30683045;
			"da": v = 32'h30600000; "di": v = 32'h30620000; "du": v = 32'h30650000;
			"de": v = 32'h30670000; "do": v = 32'h30690000;
			"dya": v = 32'h30623083; "dyu": v = 32'h30623085; "dyo": v = 32'h30623087;
			"dha": v = 32'h30673083; "dhi": v = 32'h30673043; "dhu": v = 32'h30673085;
			"dhe": v = 32'h30673047; "dho": v = 32'h30673087;
			"dwu": v = 32'h30693045;
			"na": v = 32'h306A0000; "ni": v = 32'h306B0000; "nu": v = 32'h306C0000;
			"ne": v = 32'h306D0000; "no": v = 32'h306E0000;
			"nya": v = 32'h306B3083; "nyi": v = 32'h306B3043; "nyu": v = 32'h306B3085;
			"nye": v = 32'h306B3047; "nyo": v = 32'h306B3087;
			"nn": v = 32'h30930000; "n'": v = 32'h30930000;
			"ha": v = 32'h306F0000; "hi": v = 32'h30720000; "hu": v = 32'h30750000;
			"he": v = 32'h30780000; "ho": v = 32'h307B0000;
			"hya": v = 32'h30723083; "hyu": v = 32'h30723085; "hyo": v = 32'h30723087;
			"fa": v = 32'h30753041; "fi": v = 32'h30753043; "fe": v = 32'h30753047;
			"fo": v = 32'h30753049; "fu": v = 32'h30750000;
			"fya": v = 32'h30753083; "fyu": v = 32'h30753085; "fyo": v = 32'h30753087;
			"ba": v = 32'h30700000; "bi": v = 32'h30730000; "bu": v = 32'h30760000;
			"be": v = 32'h30790000; "bo": v = 32'h307C0000;
			"bya": v = 32'h30733083; "byu": v = 32'h30733085; "byo": v = 32'h30733087;
			"pa": v = 32'h30710000; "pi": v = 32'h30740000; "pu": v = 32'h30770000;
			"pe": v = 32'h307A0000; "po": v = 32'h307D0000;
			"pya": v = 32'h30743083; "pyu": v = 32'h30743085; "pyo": v = 32'h30743087;
			"ma": v = 32'h307E0000; "mi": v = 32'h307F0000; "mu": v = 32'h30800000;
			"me": v = 32'h30810000; "mo": v = 32'h30820000;
			"mya": v = 32'h307F3083; "myu": v = 32'h307F3085; "myo": v = 32'h307F3087;
			"ya": v = 32'h30840000; "yu": v = 32'h30860000; "yo": v = 32'h30880000;
			"ye": v = 32'h30443047;
			"ra": v = 32'h30890000; "ri": v = 32'h308A0000; "ru": v = 32'h308B0000;
			"re": v = 32'h308C0000; "ro": v = 32'h308D0000;
			"rya": v = 32'h308A3083; "ryu": v = 32'h308A3085; "ryo": v = 32'h308A3087;
			"wa": v = 32'h308F0000; "wi": v = 32'h30463043; "wu": v = 32'h30460000;
			"we": v = 32'h30463047; "wo": v = 32'h30920000;
			"wha": v = 32'h30463041; "whi": v = 32'h30463043; "whe": v = 32'h30463047;
			"who": v = 32'h30463049;
			"va": v = 32'h30943041; "vi": v = 32'h30943043; "ve": v = 32'h30943047;
			"vo": v = 32'h30943049; "vu": v = 32'h30940000;
			"ca": v = 32'h304B0000; "ci": v = 32'h30570000; "cu": v = 32'h304F0000;
			"ce": v = 32'h305B0000; "co": v = 32'h30530000;
			"qa": v = 32'h304F3041; "qi": v = 32'h304F3043; "qe": v = 32'h304F3047;
			"qo": v = 32'h304F3049; "qu": v = 32'h304F0000;
			"la": v = 32'h30410000; "li": v = 32'h30430000; "lu": v = 32'h30450000;
			"le": v = 32'h30470000; "lo": v = 32'h30490000;
			"xa": v = 32'h30410000; "xi": v = 32'h30430000; "xu": v = 32'h30450000;
			"xe": v = 32'h30470000; "xo": v = 32'h30490000;
			"ltu": v = 32'h30630000; "xtu": v = 32'h30630000; "ltsu": v = 32'h30630000;
			"lya": v = 32'h30830000; "lyu": v = 32'h30850000; "lyo": v = 32'h30870000;
			"xya": v = 32'h30830000; "xyu": v = 32'h30850000; "xyo": v = 32'h30870000;
			"lwa": v = 32'h308E0000; "xwa": v = 32'h308E0000;
			"xka": v = 32'h30F50000; "xke": v = 32'h30F60000;
			"-": v = 32'h30FC0000; "/": v = 32'h30FB0000; "[": v = 32'h300C0000;
			"]": v = 32'h300D0000; "!": v = 32'hFF010000; "?": v = 32'hFF1F0000;
			"~": v = 32'h301C0000;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/romaji_kana_composer.sv =====
// ----------------------------------------------------------------------------
// Romaji kana composer
// Turns typed romaji into hiragana and symbols, one stream transfer per key.
// ----------------------------------------------------------------------------
// One table lookup unit is stepped by a small sequencer, one lookup per cycle
// while the output can take results, and the input is not ready until every
// result of the current request has moved into the output register. A key that
// only waits for more input passes the resolve and done states; each resolved
// group adds resolve, force and second-code states as it needs them, and an
// output stall holds the sequencer. Delete and clear go straight to done.
`include "romaji_kana_composer_macros.svh"

module romaji_kana_composer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [20:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code
	input  logic [1:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_code
	output logic [1:0]  m_tuser,   // out_kind
	output logic        m_tlast
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RES   = 3'd1;
	localparam logic [2:0] S_FORCE = 3'd2;
	localparam logic [2:0] S_EMIT2 = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]  state_q;
	logic        flush_q;
	logic [20:0] p_q [rkc_pkg::MAX_PENDING];
	logic [2:0]  count_q;
	logic [1:0]  len_q;
	logic [15:0] c1_q;
	logic [20:0] comma_q;
	logic [20:0] period_q;
	logic        stage_valid_q;
	logic [1:0]  stage_kind_q;
	logic [20:0] stage_code_q;
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [20:0] out_code_q;
	logic        out_last_q;

	rkc_pkg::lookup_t lk;
	logic [2:0]  lk_len;
	logic        out_free;
	logic        can_emit;
	logic        emit_go;
	logic [1:0]  emit_kind;
	logic [20:0] emit_code;
	logic        final_go;
	logic [1:0]  drop_n;
	logic [20:0] drop_p [rkc_pkg::MAX_PENDING];
	logic [20:0] in_char;
	logic [20:0] fb_code;
	logic        dbl;

	assign lk_len = (state_q == S_FORCE) ? {1'b0, len_q} : count_q;

	rkc_lookup u_lookup (
		.chars       (p_q),
		.len         (lk_len),
		.comma_code  (comma_q),
		.period_code (period_q),
		.res         (lk)
	);

	assign out_free = !out_valid_q || m_tready;
	assign can_emit = !stage_valid_q || out_free;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, out_code_q};
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;

	assign in_char = ((s_tdata[20:0] >= 21'h41) && (s_tdata[20:0] <= 21'h5A)) ?
		(s_tdata[20:0] + 21'h20) : s_tdata[20:0];

	assign dbl = (count_q >= 3'd2) && (((p_q[0] == p_q[1]) && rkc_pkg::is_doubling(p_q[0])) ||
		((p_q[0] == rkc_pkg::CH_LOWER_T) && (p_q[1] == rkc_pkg::CH_LOWER_C)));
	assign fb_code = dbl ? rkc_pkg::SMALL_TSU :
		(p_q[0] == rkc_pkg::CH_LOWER_N) ? rkc_pkg::SYLL_N : p_q[0];

	assign drop_n = ((state_q == S_FORCE) && (len_q != 2'd0)) ? len_q : 2'd1;

	always_comb begin
		for (int i = 0; i < rkc_pkg::MAX_PENDING; i++) begin
			if ((i + int'(drop_n)) < rkc_pkg::MAX_PENDING) begin
				drop_p[i] = p_q[2'(i + int'(drop_n))];
			end else begin
				drop_p[i] = 21'h0;
			end
		end
	end

	always_comb begin
		emit_go = 1'b0;
		emit_kind = rkc_pkg::KIND_CHAR;
		emit_code = 21'h0;
		final_go = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && (s_tuser == rkc_pkg::REQ_DELETE) && (count_q == 3'd0)) begin
					emit_go = 1'b1;
					emit_kind = rkc_pkg::KIND_RETRACT;
				end else if (s_tvalid && (s_tuser == rkc_pkg::REQ_CLEAR)) begin
					emit_go = 1'b1;
					emit_kind = rkc_pkg::KIND_CLEAR;
				end
			end
			S_RES: begin
				if ((count_q != 3'd0) && lk.match && (flush_q || !lk.ext) && can_emit) begin
					emit_go = 1'b1;
					emit_code = lk.v0;
				end
			end
			S_FORCE: begin
				if (len_q != 2'd0) begin
					if (lk.match && can_emit) begin
						emit_go = 1'b1;
						emit_code = lk.v0;
					end
				end else if (can_emit) begin
					emit_go = 1'b1;
					emit_code = fb_code;
				end
			end
			S_EMIT2: begin
				if (can_emit) begin
					emit_go = 1'b1;
					emit_code = {5'h0, c1_q};
				end
			end
			S_DONE: begin
				final_go = stage_valid_q && out_free;
			end
			default: begin
				emit_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comma_q <= 21'h03001;
			period_q <= 21'h03002;
		end else if (cfg_we) begin
			if (cfg_index) begin
				period_q <= cfg_data;
			end else begin
				comma_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			stage_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_go) begin
				if (stage_valid_q) begin
					out_valid_q <= 1'b1;
					out_kind_q <= stage_kind_q;
					out_code_q <= stage_code_q;
					out_last_q <= 1'b0;
				end
				stage_valid_q <= 1'b1;
				stage_kind_q <= emit_kind;
				stage_code_q <= emit_code;
			end
			if (final_go) begin
				out_valid_q <= 1'b1;
				out_kind_q <= stage_kind_q;
				out_code_q <= stage_code_q;
				out_last_q <= 1'b1;
				stage_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			flush_q <= 1'b0;
			count_q <= 3'd0;
			len_q <= 2'd0;
			for (int i = 0; i < rkc_pkg::MAX_PENDING; i++) begin
				p_q[i] <= 21'h0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						unique case (s_tuser)
							rkc_pkg::REQ_KEY: begin
								p_q[count_q[1:0]] <= in_char;
								count_q <= count_q + 3'd1;
								flush_q <= 1'b0;
								state_q <= S_RES;
							end
							rkc_pkg::REQ_FLUSH: begin
								flush_q <= 1'b1;
								state_q <= S_RES;
							end
							rkc_pkg::REQ_DELETE: begin
								if (count_q != 3'd0) begin
									count_q <= count_q - 3'd1;
									p_q[2'(count_q - 3'd1)] <= 21'h0;
								end
								state_q <= S_DONE;
							end
							default: begin
								for (int i = 0; i < rkc_pkg::MAX_PENDING; i++) begin
									p_q[i] <= 21'h0;
								end
								count_q <= 3'd0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RES: begin
					if (count_q == 3'd0) begin
						state_q <= S_DONE;
					end else if (lk.match && (flush_q || !lk.ext)) begin
						if (can_emit) begin
							for (int i = 0; i < rkc_pkg::MAX_PENDING; i++) begin
								p_q[i] <= 21'h0;
							end
							count_q <= 3'd0;
							c1_q <= lk.v1;
							if (lk.v1 != 16'h0) begin
								state_q <= S_EMIT2;
							end
						end
					end else if (!flush_q && lk.ext) begin
						state_q <= S_DONE;
					end else begin
						len_q <= 2'(count_q - 3'd1);
						state_q <= S_FORCE;
					end
				end
				S_FORCE: begin
					if ((len_q != 2'd0) && !lk.match) begin
						len_q <= len_q - 2'd1;
					end else if (can_emit) begin
						p_q <= drop_p;
						count_q <= count_q - {1'b0, drop_n};
						c1_q <= lk.v1;
						if ((len_q != 2'd0) && (lk.v1 != 16'h0)) begin
							state_q <= S_EMIT2;
						end else begin
							state_q <= S_RES;
						end
					end
				end
				S_EMIT2: begin
					if (can_emit) begin
						state_q <= S_RES;
					end
				end
				S_DONE: begin
					if (!stage_valid_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`RKC_ASSERT_SAME(a_idle_stage_empty, state_q == S_IDLE, !stage_valid_q)
	`RKC_ASSERT_SAME(a_count_bound, 1'b1, count_q <= 3'd4)
	`RKC_ASSERT_SAME(a_force_holds, state_q == S_FORCE, count_q != 3'd0)
	`RKC_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_q != S_IDLE)

endmodule

// ===== rtl/rkc_lookup.sv =====
// ----------------------------------------------------------------------------
// Romaji table lookup
// Matches the head of the held string against the romaji table.
// ----------------------------------------------------------------------------
module rkc_lookup (
	input  logic [rkc_pkg::CODE_W-1:0] chars [rkc_pkg::MAX_PENDING],
	input  logic [2:0]                 len,
	input  logic [rkc_pkg::CODE_W-1:0] comma_code,
	input  logic [rkc_pkg::CODE_W-1:0] period_code,
	output rkc_pkg::lookup_t           res
);

	logic [3:0]  ok;
	logic        bad;
	logic [31:0] key;
	logic [31:0] val;
	logic        is_comma;
	logic        is_period;

	always_comb begin
		for (int i = 0; i < rkc_pkg::MAX_PENDING; i++) begin
			ok[i] = (chars[i][20:7] == 14'd0) && (chars[i][6:0] != 7'd0);
		end
		bad = 1'b0;
		key = 32'h0;
		unique case (len)
			3'd1: begin
				bad = !ok[0];
				key = {24'h0, chars[0][7:0]};
			end
			3'd2: begin
				bad = !(ok[0] && ok[1]);
				key = {16'h0, chars[0][7:0], chars[1][7:0]};
			end
			3'd3: begin
				bad = !(ok[0] && ok[1] && ok[2]);
				key = {8'h0, chars[0][7:0], chars[1][7:0], chars[2][7:0]};
			end
			3'd4: begin
				bad = !(ok[0] && ok[1] && ok[2] && ok[3]);
				key = {chars[0][7:0], chars[1][7:0], chars[2][7:0], chars[3][7:0]};
			end
			default: begin
				bad = 1'b1;
				key = 32'h0;
			end
		endcase
		val = rkc_pkg::kana_value(key);
		is_comma = (len == 3'd1) && (chars[0] == rkc_pkg::CH_COMMA);
		is_period = (len == 3'd1) && (chars[0] == rkc_pkg::CH_PERIOD);
		res.match = is_comma || is_period || (!bad && (val != 32'h0));
		res.ext = !bad && rkc_pkg::kana_prefix(key);
		if (is_comma) begin
			res.v0 = comma_code;
			res.v1 = 16'h0;
		end else if (is_period) begin
			res.v0 = period_code;
			res.v1 = 16'h0;
		end else begin
			res.v0 = {5'h0, val[31:16]};
			res.v1 = val[15:0];
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Romaji kana composer testbench
// Drives keys, flushes, deletes and clears through the input stream, predicts
// every committed code, retract and clear, and checks the output stream with
// random idling on both sides under three register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
	logic [1:0]  kind;
	logic [20:0] code;
	logic        last;
} kana_result_t;

class kana_scoreboard;
	logic [20:0]  comma_cp;
	logic [20:0]  period_cp;
	logic [20:0]  held[rkc_pkg::MAX_PENDING];
	int           n_held;
	bit [31:0]    romaji[string];
	bit           stem[string];
	kana_result_t step_q[$];
	kana_result_t kana_q[$];
	int           errors;
	int           n_checked;
	int           n_items;

	function new();
		comma_cp = 21'h3001;
		period_cp = 21'h3002;
		n_held = 0;
		errors = 0;
		n_checked = 0;
		n_items = 0;
		foreach (held[i]) held[i] = '0;
		put("a", 'h3042); put("i", 'h3044); put("u", 'h3046); put("e", 'h3048);
		put("o", 'h304A);
		put("ka", 'h304B); put("ki", 'h304D); put("ku", 'h304F); put("ke", 'h3051);
		put("ko", 'h3053); y5("ky", 'h304D);
		put("ga", 'h304C); put("gi", 'h304E); put("gu", 'h3050); put("ge", 'h3052);
		put("go", 'h3054); yo("gy", 'h304E);
		put("sa", 'h3055); put("si", 'h3057); put("su", 'h3059); put("se", 'h305B);
		put("so", 'h305D); yo("sh", 'h3057); put("shi", 'h3057);
		put("she", 'h3057, 'h3047); y5("sy", 'h3057);
		put("za", 'h3056); put("zi", 'h3058); put("zu", 'h305A); put("ze", 'h305C);
		put("zo", 'h305E); yo("j", 'h3058); put("ji", 'h3058);
		put("je", 'h3058, 'h3047); yo("jy", 'h3058); y5("zy", 'h3058);
		put("ta", 'h305F); put("ti", 'h3061); put("tu", 'h3064); put("te", 'h3066);
		put("to", 'h3068); yo("ch", 'h3061); put("chi", 'h3061);
		put("che", 'h3061, 'h3047); y5("ty", 'h3061);
		put("tsu", 'h3064); sv("ts", 'h3064); y5("th", 'h3066);
		put("twu", 'h3068, 'h3045);
		put("da", 'h3060); put("di", 'h3062); put("du", 'h3065); put("de", 'h3067);
		put("do", 'h3069); yo("dy", 'h3062); y5("dh", 'h3067);
		put("dwu", 'h3069, 'h3045);
		put("na", 'h306A); put("ni", 'h306B); put("nu", 'h306C); put("ne", 'h306D);
		put("no", 'h306E); y5("ny", 'h306B);
		put("nn", rkc_pkg::SYLL_N); put("n'", rkc_pkg::SYLL_N);
		put("ha", 'h306F); put("hi", 'h3072); put("hu", 'h3075); put("he", 'h3078);
		put("ho", 'h307B); yo("hy", 'h3072);
		sv("f", 'h3075); put("fu", 'h3075); yo("fy", 'h3075);
		put("ba", 'h3070); put("bi", 'h3073); put("bu", 'h3076); put("be", 'h3079);
		put("bo", 'h307C); yo("by", 'h3073);
		put("pa", 'h3071); put("pi", 'h3074); put("pu", 'h3077); put("pe", 'h307A);
		put("po", 'h307D); yo("py", 'h3074);
		put("ma", 'h307E); put("mi", 'h307F); put("mu", 'h3080); put("me", 'h3081);
		put("mo", 'h3082); yo("my", 'h307F);
		put("ya", 'h3084); put("yu", 'h3086); put("yo", 'h3088);
		put("ye", 'h3044, 'h3047);
		put("ra", 'h3089); put("ri", 'h308A); put("ru", 'h308B); put("re", 'h308C);
		put("ro", 'h308D); yo("ry", 'h308A);
		put("wa", 'h308F); put("wi", 'h3046, 'h3043); put("wu", 'h3046);
		put("we", 'h3046, 'h3047); put("wo", 'h3092); sv("wh", 'h3046);
		sv("v", 'h3094); put("vu", 'h3094);
		put("ca", 'h304B); put("ci", 'h3057); put("cu", 'h304F); put("ce", 'h305B);
		put("co", 'h3053);
		sv("q", 'h304F); put("qu", 'h304F);
		put("la", 'h3041); put("li", 'h3043); put("lu", 'h3045); put("le", 'h3047);
		put("lo", 'h3049);
		put("xa", 'h3041); put("xi", 'h3043); put("xu", 'h3045); put("xe", 'h3047);
		put("xo", 'h3049);
		put("ltu", rkc_pkg::SMALL_TSU); put("xtu", rkc_pkg::SMALL_TSU);
		put("ltsu", rkc_pkg::SMALL_TSU);
		put("lya", 'h3083); put("lyu", 'h3085); put("lyo", 'h3087);
		put("xya", 'h3083); put("xyu", 'h3085); put("xyo", 'h3087);
		put("lwa", 'h308E); put("xwa", 'h308E); put("xka", 'h30F5); put("xke", 'h30F6);
		put("-", 'h30FC); put("/", 'h30FB); put("[", 'h300C); put("]", 'h300D);
		put("!", 'hFF01); put("?", 'hFF1F); put("~", 'h301C);
	endfunction

	function void put(string k, int c0, int c1 = 0);
		romaji[k] = {c0[15:0], c1[15:0]};
		for (int l = 1; l < k.len(); l++) stem[k.substr(0, l - 1)] = 1'b1;
	endfunction

	function void yo(string k, int c);
		put({k, "a"}, c, 'h3083); put({k, "u"}, c, 'h3085); put({k, "o"}, c, 'h3087);
	endfunction

	function void y5(string k, int c);
		yo(k, c); put({k, "i"}, c, 'h3043); put({k, "e"}, c, 'h3047);
	endfunction

	function void sv(string k, int c);
		put({k, "a"}, c, 'h3041); put({k, "i"}, c, 'h3043);
		put({k, "e"}, c, 'h3047); put({k, "o"}, c, 'h3049);
	endfunction

	function bit held_key(int n, output string s);
		byte b;
		s = "";
		for (int i = 0; i < n; i++) begin
			if (held[i] == 0 || held[i] > 127) return 1'b0;
			b = held[i][7:0];
			s = {s, string'(b)};
		end
		return 1'b1;
	endfunction

	function void emit(logic [1:0] kind, logic [20:0] code);
		kana_result_t r;
		if (step_q.size() >= 8) return;
		r.kind = kind;
		r.code = code;
		r.last = 1'b0;
		step_q = {step_q, r};
	endfunction

	// Looks up the first n held characters; emits the value unless dry.
	function bit lookup(int n, bit dry);
		string s;
		bit [31:0] v;
		if (n == 1 && held[0] == rkc_pkg::CH_COMMA) begin
			if (!dry) emit(rkc_pkg::KIND_CHAR, comma_cp);
			return 1'b1;
		end
		if (n == 1 && held[0] == rkc_pkg::CH_PERIOD) begin
			if (!dry) emit(rkc_pkg::KIND_CHAR, period_cp);
			return 1'b1;
		end
		if (!held_key(n, s) || !romaji.exists(s)) return 1'b0;
		v = romaji[s];
		if (!dry) begin
			emit(rkc_pkg::KIND_CHAR, {5'b0, v[31:16]});
			if (v[15:0] != 0) emit(rkc_pkg::KIND_CHAR, {5'b0, v[15:0]});
		end
		return 1'b1;
	endfunction

	function bit extendable(int n);
		string s;
		return held_key(n, s) && stem.exists(s);
	endfunction

	function void drop_head(int n);
		for (int i = 0; i < rkc_pkg::MAX_PENDING; i++)
			held[i] = (i + n < n_held) ? held[i + n] : 21'h0;
		n_held -= n;
	endfunction

	function void empty_held();
		foreach (held[i]) held[i] = '0;
		n_held = 0;
	endfunction

	function void force_head();
		logic [20:0] a, b;
		bit dbl;
		if (n_held == 0) return;
		for (int len = n_held - 1; len >= 1; len--)
			if (lookup(len, 1'b0)) begin
				drop_head(len);
				return;
			end
		a = held[0];
		b = held[1];
		dbl = a >= "a" && a <= "z" && !(a inside {"a", "e", "i", "o", "u", "n"});
		if (n_held >= 2 && ((a == b && dbl) ||
			(a == rkc_pkg::CH_LOWER_T && b == rkc_pkg::CH_LOWER_C)))
			emit(rkc_pkg::KIND_CHAR, rkc_pkg::SMALL_TSU);
		else if (a == rkc_pkg::CH_LOWER_N)
			emit(rkc_pkg::KIND_CHAR, rkc_pkg::SYLL_N);
		else
			emit(rkc_pkg::KIND_CHAR, a);
		drop_head(1);
	endfunction

	function void note(logic [1:0] req, logic [20:0] ch);
		n_items++;
		step_q.delete();
		case (req)
			rkc_pkg::REQ_KEY: begin
				if (ch >= "A" && ch <= "Z") ch = ch + 21'd32;
				if (n_held >= rkc_pkg::MAX_PENDING) force_head();
				held[n_held] = ch;
				n_held++;
				while (n_held > 0) begin
					if (extendable(n_held)) break;
					if (lookup(n_held, 1'b0)) empty_held();
					else force_head();
				end
			end
			rkc_pkg::REQ_FLUSH: begin
				while (n_held > 0)
					if (lookup(n_held, 1'b0)) empty_held();
					else force_head();
			end
			rkc_pkg::REQ_DELETE: begin
				if (n_held > 0) begin
					n_held--;
					held[n_held] = '0;
				end else begin
					emit(rkc_pkg::KIND_RETRACT, '0);
				end
			end
			default: begin
				empty_held();
				emit(rkc_pkg::KIND_CLEAR, '0);
			end
		endcase
		if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
		kana_q = {kana_q, step_q};
	endfunction

	function void check(logic [1:0] kind, logic [20:0] code, logic last);
		kana_result_t e;
		n_checked++;
		if (kana_q.size() == 0) begin
			$display("%0t: unexpected transfer kind %0d code %h last %0d",
				$time, kind, code, last);
			errors++;
			return;
		end
		e = kana_q.pop_front();
		if (e.kind !== kind || e.code !== code || e.last !== last) begin
			$display("%0t: mismatch expected kind %0d code %h last %0d, got %0d %h %0d",
				$time, e.kind, e.code, e.last, kind, code, last);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam logic CFG_COMMA = 1'b0;
	localparam logic CFG_PERIOD = 1'b1;
	localparam int STALL_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [20:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int src_idle = 0;
	int snk_idle = 0;
	int quiet_cycles = 0;
	kana_scoreboard kana_sb = new();

	romaji_kana_composer dut (.*);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			kana_sb.check(m_tuser, m_tdata[20:0], m_tlast);
		m_tready <= ($urandom_range(0, 99) >= snk_idle);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL romaji_kana_composer");
			$finish;
		end
	end

	task automatic send(logic [1:0] req, logic [20:0] ch);
		if ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {3'b0, ch};
		do @(posedge clk); while (!s_tready);
		kana_sb.note(req, ch);
	endtask

	task automatic type_text(string s);
		foreach (s[i]) send(rkc_pkg::REQ_KEY, {13'b0, s[i]});
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (kana_sb.kana_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [20:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_COMMA) kana_sb.comma_cp = val;
		else kana_sb.period_cp = val;
		@(posedge clk);
	endtask

	task automatic random_item();
		string letters = "aiueokstnhmyrwgzdbpcfjlqvx,.-/[]!?~'";
		int r = $urandom_range(0, 99);
		if (r < 70)
			send(rkc_pkg::REQ_KEY, {13'b0, letters[$urandom_range(0, letters.len() - 1)]});
		else if (r < 76)
			send(rkc_pkg::REQ_KEY, 21'h41 + 21'($urandom_range(0, 25)));
		else if (r < 82)
			send(rkc_pkg::REQ_KEY, 21'($urandom));
		else if (r < 90)
			send(rkc_pkg::REQ_FLUSH, 21'($urandom));
		else if (r < 95)
			send(rkc_pkg::REQ_DELETE, 21'($urandom));
		else
			send(rkc_pkg::REQ_CLEAR, 21'($urandom));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 20;
		snk_idle = 83;
		send(rkc_pkg::REQ_DELETE, '0);
		send(rkc_pkg::REQ_FLUSH, 21'h1FFFFF);
		type_text("KYa");
		type_text("nnnkakkatca");
		type_text("ltsushe,.");
		send(rkc_pkg::REQ_KEY, 21'h1FFFFF);
		send(rkc_pkg::REQ_KEY, 21'h0);
		type_text("sh");
		send(rkc_pkg::REQ_DELETE, '0);
		send(rkc_pkg::REQ_FLUSH, '0);
		type_text("ky");
		send(rkc_pkg::REQ_CLEAR, 21'h1FFFFF);
		repeat (30) random_item();
		drain();

		write_reg(CFG_COMMA, 21'h1FFFFF);
		write_reg(CFG_PERIOD, 21'h0);
		src_idle = 83;
		snk_idle = 20;
		type_text(",.");
		repeat (30) random_item();
		drain();

		write_reg(CFG_COMMA, 21'h0);
		write_reg(CFG_PERIOD, 21'h1FFFFF);
		src_idle = 0;
		snk_idle = 0;
		repeat (30) random_item();
		send(rkc_pkg::REQ_FLUSH, '0);
		drain();

		$display("Covered %0d requests and %0d output transfers under three register settings",
			kana_sb.n_items, kana_sb.n_checked);
		if (kana_sb.errors == 0 && kana_sb.kana_q.size() == 0) begin
			$display("PASS romaji_kana_composer");
		end else begin
			$display("FAIL romaji_kana_composer");
		end
		$finish;
	end
endmodule
